@@ src/assert_macros.svh @@
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/drwq_pkg.sv @@
// shared constants and types for the delayed register write queue
package drwq_pkg;

  localparam int DEF_QUEUE_DEPTH  = 64;
  localparam int DEF_WINDOW_BYTES = 256;

  localparam logic [15:0] DEF_RELEASE_DELAY = 16'd512;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic        half;
    logic [7:0]  offset;
    logic [31:0] value;
  } out_item_t;

  typedef struct packed {
    logic [15:0] rel;
    out_item_t   item;
  } ring_entry_t;

endpackage

@@ src/drwq_shadow.sv @@
// shadow copy of the register window: registered-read memory with per-word valid bits
module drwq_shadow #(
  parameter int WORDS = drwq_pkg::DEF_WINDOW_BYTES / 4,
  parameter int AW    = $clog2(WORDS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data
);

  logic [31:0]      mem [WORDS];
  logic [31:0]      mem_q;
  logic             hit;
  logic [WORDS-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      hit   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit <= valid[rd_addr];
      end
    end
  end

  // never-written words read as zero
  assign rd_data = hit ? mem_q : 32'd0;

endmodule

@@ src/delayed_register_write_queue_core.sv @@
// delayed register write queue: shadowed masked writes released on sample ticks
// a write reads the shadow, then merges and writes back; an overflow write then
// places its result in the output register
// a tick on an empty ring ends at acceptance, else each entry examined gets a due check,
// then an output load, plus a last load when the ring runs empty; output stalls hold the loads
// synchronous reset clears pointers, tick time, valid bits and sets release_delay to 512
module delayed_register_write_queue_core
  #(
  parameter int QUEUE_DEPTH  = drwq_pkg::DEF_QUEUE_DEPTH,
  parameter int WINDOW_BYTES = drwq_pkg::DEF_WINDOW_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  reg_offset,
  input  logic [31:0] write_value,
  input  logic [31:0] write_mask,
  input  logic        half_width,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_offset,
  output logic [31:0] out_value,
  output logic        out_half_width,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  import drwq_pkg::*;

  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int WORDS = (WINDOW_BYTES + 3) / 4;
  localparam int AW    = $clog2(WORDS);

  localparam logic [8:0]    WIN_LIMIT = 9'(WINDOW_BYTES);
  localparam logic [PW-1:0] PTR_LAST  = PW'(QUEUE_DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WMOD  = 5'b00010,
    S_TCHK  = 5'b00100,
    S_TPUSH = 5'b01000,
    S_LAST  = 5'b10000
  } state_t;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  state_t        state, state_next;
  logic [PW-1:0] head, tail;
  logic [15:0]   tick_time;
  logic [15:0]   release_delay;

  logic          have_cand;
  out_item_t     cand;
  out_item_t     nxt;
  logic          nxt_due;

  logic [7:0]    wr_off;
  logic [31:0]   wr_val;
  logic [31:0]   wr_msk;
  logic          wr_half;

  ring_entry_t   ring_mem [QUEUE_DEPTH];
  ring_entry_t   ring_rdata;

  logic          in_xfer, out_free;
  logic [7:0]    off_al;
  logic          in_range;
  logic          shd_rd;
  logic [31:0]   shd_word;
  logic [15:0]   old_h, new_h;
  logic [31:0]   new_v, word_new;
  logic          changed, full;
  logic [15:0]   remaining;
  logic          due;
  logic          ring_rd, ring_wr;
  logic          load_out, load_last;
  out_item_t     load_item;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign off_al   = half_width ? {reg_offset[7:1], 1'b0} : {reg_offset[7:2], 2'b00};
  assign in_range = ({1'b0, off_al} < WIN_LIMIT);
  assign shd_rd   = in_xfer && (opcode == OP_WRITE) && in_range;

  drwq_shadow #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_shadow (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (shd_rd),
    .rd_addr (off_al[AW+1:2]),
    .rd_data (shd_word),
    .wr_en   (state == S_WMOD && changed),
    .wr_addr (wr_off[AW+1:2]),
    .wr_data (word_new)
  );

  // merge under mask
  always_comb begin
    old_h    = wr_off[1] ? shd_word[31:16] : shd_word[15:0];
    new_h    = (old_h & ~wr_msk[15:0]) | (wr_val[15:0] & wr_msk[15:0]);
    if (wr_half) begin
      new_v    = {16'd0, new_h};
      changed  = (new_h != old_h);
      word_new = wr_off[1] ? {new_h, shd_word[15:0]} : {shd_word[31:16], new_h};
    end else begin
      new_v    = (shd_word & ~wr_msk) | (wr_val & wr_msk);
      changed  = (new_v != shd_word);
      word_new = new_v;
    end
  end

  assign full      = (ptr_inc(tail) == head);
  assign remaining = ring_rdata.rel - tick_time;
  assign due       = (remaining == 16'd0) || (remaining > release_delay);
  assign ring_wr   = (state == S_WMOD) && changed && !full;

  always_comb begin
    state_next = state;
    ring_rd    = 1'b0;
    load_out   = 1'b0;
    load_last  = 1'b0;
    load_item  = cand;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (opcode == OP_TICK) begin
            if (head != tail) begin
              ring_rd    = 1'b1;
              state_next = S_TCHK;
            end
          end else if (in_range) begin
            state_next = S_WMOD;
          end
        end
      end
      S_WMOD: begin
        state_next = (changed && full) ? S_LAST : S_IDLE;
      end
      S_TCHK: begin
        state_next = S_TPUSH;
      end
      S_TPUSH: begin
        if (!have_cand || out_free) begin
          load_out  = have_cand;
          load_last = !nxt_due;
          if (nxt_due) begin
            if (head != tail) begin
              ring_rd    = 1'b1;
              state_next = S_TCHK;
            end else begin
              state_next = S_LAST;
            end
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_LAST: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // pending ring memory
  always_ff @(posedge clk) begin
    if (ring_wr) begin
      ring_mem[tail] <= '{rel: tick_time + release_delay,
                          item: '{half: wr_half, offset: wr_off, value: new_v}};
    end
    if (ring_rd) begin
      ring_rdata <= ring_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      tail          <= '0;
      tick_time     <= '0;
      release_delay <= DEF_RELEASE_DELAY;
      have_cand     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        release_delay <= cfg_wdata;
      end
      if (in_xfer && opcode == OP_TICK) begin
        tick_time <= tick_time + 16'd1;
        have_cand <= 1'b0;
      end
      if (ring_wr) begin
        tail <= ptr_inc(tail);
      end
      if (state == S_TCHK && due) begin
        head <= ptr_inc(head);
      end
      if (state == S_TPUSH && state_next != S_TPUSH && nxt_due) begin
        have_cand <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && opcode == OP_WRITE) begin
      wr_off  <= off_al;
      wr_val  <= write_value;
      wr_msk  <= write_mask;
      wr_half <= half_width;
    end
    if (state == S_WMOD) begin
      cand <= '{half: wr_half, offset: wr_off, value: new_v};
    end
    if (state == S_TCHK) begin
      nxt     <= ring_rdata.item;
      nxt_due <= due;
    end
    if (state == S_TPUSH && state_next != S_TPUSH && nxt_due) begin
      cand <= nxt;
    end
    if (load_out) begin
      out_offset     <= load_item.offset;
      out_value      <= load_item.value;
      out_half_width <= load_item.half;
      out_last       <= load_last;
    end
  end

endmodule

@@ src/drwq_checker.sv @@
// port-level checks for the delayed register write queue, bound to the top level
`include "assert_macros.svh"

module drwq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_offset,
  input logic [31:0] out_value,
  input logic        out_half_width,
  input logic        out_last
);

  logic [41:0] out_bundle;
  logic        mid_xfer;
  logic        word_ok;
  logic        half_ok;

  assign out_bundle = {out_offset, out_value, out_half_width, out_last};
  assign mid_xfer   = out_valid && out_ready && !out_last;
  assign word_ok    = (out_offset[1:0] == 2'b00);
  assign half_ok    = (out_offset[0] == 1'b0) && (out_value[31:16] == 16'd0);

  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bundle), "hold broken")
  `CHK_NEXT(a_busy_until_last, mid_xfer, out_valid || !in_ready, "input taken mid-burst")
  `CHK_SAME(a_word_align, out_valid && !out_half_width, word_ok, "word write not aligned")
  `CHK_SAME(a_half_shape, out_valid && out_half_width, half_ok, "half-word write malformed")

endmodule

bind delayed_register_write_queue_core drwq_checker u_drwq_checker (.*);

@@ dv/drwq_release_monitor.sv @@
// release monitor: predicts issued register writes from accepted requests and checks the output
module drwq_release_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  reg_offset,
  input  logic [31:0] write_value,
  input  logic [31:0] write_mask,
  input  logic        half_width,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_offset,
  input  logic [31:0] out_value,
  input  logic        out_half_width,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          writes_owed
);
  import drwq_pkg::*;

  localparam int RING_SLOTS = DEF_QUEUE_DEPTH;
  localparam int MAX_BURST  = 64;

  typedef struct {
    out_item_t item;
    logic      last;
  } issued_write_t;

  logic [31:0]   shadow_words [0:63];
  ring_entry_t   pending      [0:63];
  logic [5:0]    ring_rd;
  logic [5:0]    ring_wr;
  logic [15:0]   tick_now;
  logic [15:0]   hold_ticks;
  issued_write_t owed_writes [$];
  int            mismatches;

  assign fail_count  = mismatches;
  assign writes_owed = owed_writes.size();

  initial mismatches = 0;

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic clear_state();
    for (int i = 0; i < 64; i++) begin
      shadow_words[i] = '0;
      pending[i] = '0;
    end
    ring_rd = '0;
    ring_wr = '0;
    tick_now = '0;
    hold_ticks = DEF_RELEASE_DELAY;
    owed_writes.delete();
  endtask

  // one accepted request: merge into the shadow, queue (or issue at once when full), or drain on a tick
  task automatic apply_request(input logic op, input logic [7:0] off_in,
                               input logic [31:0] val, input logic [31:0] msk,
                               input logic half);
    logic [7:0]    off;
    logic [31:0]   word;
    logic [31:0]   new_val;
    logic [15:0]   old_half;
    logic [15:0]   new_half;
    logic [15:0]   slack;
    logic [5:0]    fill;
    logic          draining;
    int            n;
    ring_entry_t   ent;
    issued_write_t rec;
    if (op == OP_TICK) begin
      tick_now = tick_now + 16'd1;
      n = 0;
      draining = 1'b1;
      while (draining && ring_rd != ring_wr && n < MAX_BURST) begin
        ent = pending[ring_rd];
        slack = ent.rel - tick_now;
        if (slack == 16'd0 || slack > hold_ticks) begin
          rec.item = ent.item;
          rec.last = 1'b0;
          owed_writes.push_back(rec);
          n++;
          ring_rd = ring_rd + 6'd1;
        end else begin
          draining = 1'b0;
        end
      end
      if (n > 0) begin
        rec = owed_writes.pop_back();
        rec.last = 1'b1;
        owed_writes.push_back(rec);
      end
      return;
    end
    off = half ? {off_in[7:1], 1'b0} : {off_in[7:2], 2'b00};
    word = shadow_words[off[7:2]];
    if (half) begin
      old_half = off[1] ? word[31:16] : word[15:0];
      new_half = (old_half & ~msk[15:0]) | (val[15:0] & msk[15:0]);
      if (new_half == old_half) return;
      new_val = {16'h0000, new_half};
      if (off[1]) word[31:16] = new_half;
      else word[15:0] = new_half;
    end else begin
      new_val = (word & ~msk) | (val & msk);
      if (new_val == word) return;
      word = new_val;
    end
    shadow_words[off[7:2]] = word;
    fill = ring_wr - ring_rd;
    if (int'(fill) < RING_SLOTS - 1) begin
      ent.rel = tick_now + hold_ticks;
      ent.item.half = half;
      ent.item.offset = off;
      ent.item.value = new_val;
      pending[ring_wr] = ent;
      ring_wr = ring_wr + 6'd1;
    end else begin
      // ring full, issued at once
      rec.item.half = half;
      rec.item.offset = off;
      rec.item.value = new_val;
      rec.last = 1'b1;
      owed_writes.push_back(rec);
    end
  endtask

  task automatic check_issued();
    issued_write_t want;
    if (owed_writes.size() == 0) begin
      flag_mismatch($sformatf("register write to %02h with none pending", out_offset));
      return;
    end
    want = owed_writes.pop_front();
    if (out_offset !== want.item.offset)
      flag_mismatch($sformatf("out_offset %02h, want %02h", out_offset, want.item.offset));
    if (out_value !== want.item.value)
      flag_mismatch($sformatf("out_value %08h, want %08h", out_value, want.item.value));
    if (out_half_width !== want.item.half)
      flag_mismatch($sformatf("out_half_width %b, want %b", out_half_width, want.item.half));
    if (out_last !== want.last)
      flag_mismatch($sformatf("out_last %b, want %b", out_last, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (cfg_we) hold_ticks = cfg_wdata;
      if (in_valid && in_ready)
        apply_request(opcode, reg_offset, write_value, write_mask, half_width);
      if (out_valid && out_ready) check_issued();
    end
  end

endmodule

@@ dv/delayed_register_write_queue_core_tb.sv @@
// testbench top: drives write and tick requests, delay settings and the verdict
module delayed_register_write_queue_core_tb;
  import drwq_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic        opcode         = OP_WRITE;
  logic [7:0]  reg_offset     = '0;
  logic [31:0] write_value    = '0;
  logic [31:0] write_mask     = '0;
  logic        half_width     = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [7:0]  out_offset;
  logic [31:0] out_value;
  logic        out_half_width;
  logic        out_last;
  logic        cfg_we         = 1'b0;
  logic [15:0] cfg_wdata      = '0;

  int   fail_count;
  int   writes_owed;
  int   cycle_count = 0;
  logic calm        = 1'b0;
  logic [15:0] phase_delays [0:6] = '{16'd1, 16'd3, 16'd0, 16'd2, 16'd16, 16'hffff, 16'd5};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  delayed_register_write_queue_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .reg_offset     (reg_offset),
    .write_value    (write_value),
    .write_mask     (write_mask),
    .half_width     (half_width),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_offset     (out_offset),
    .out_value      (out_value),
    .out_half_width (out_half_width),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  drwq_release_monitor monitor (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .reg_offset     (reg_offset),
    .write_value    (write_value),
    .write_mask     (write_mask),
    .half_width     (half_width),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_offset     (out_offset),
    .out_value      (out_value),
    .out_half_width (out_half_width),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .writes_owed    (writes_owed)
  );

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("delayed_register_write_queue_core_tb: done, errors");
      $finish;
    end
  end

  task automatic send_request(input logic op, input logic [7:0] off, input logic [31:0] val,
                              input logic [31:0] msk, input logic half);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    reg_offset <= off;
    write_value <= val;
    write_mask <= msk;
    half_width <= half;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_tick();
    send_request(OP_TICK, 8'($urandom_range(255)), $urandom, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic send_random_write();
    logic [31:0] msk;
    case ($urandom_range(9))
      0: msk = '0;
      1: msk = 32'd1 << $urandom_range(31);
      2, 3: msk = $urandom;
      default: msk = '1;
    endcase
    send_request(OP_WRITE, 8'($urandom_range(255)), $urandom, msk, 1'($urandom_range(1)));
  endtask

  // wait for the block to go quiet, then load a new release delay
  task automatic set_release_delay(input logic [15:0] ticks);
    @(negedge clk);
    in_valid <= 1'b0;
    while (writes_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= ticks;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset delay, shadow all zeros
    send_request(OP_WRITE, 8'h00, 32'hffffffff, 32'hffffffff, 1'b0);
    send_request(OP_WRITE, 8'h00, 32'hffffffff, 32'hffffffff, 1'b0);
    send_request(OP_WRITE, 8'h00, 32'h00000000, 32'h00000000, 1'b0);
    send_request(OP_WRITE, 8'hff, 32'h0000ffff, 32'h0000ffff, 1'b1);
    send_request(OP_WRITE, 8'h03, 32'h00000000, 32'hffffffff, 1'b0);
    send_request(OP_WRITE, 8'h02, 32'h12345678, 32'hffff0000, 1'b1);
    send_request(OP_WRITE, 8'h81, 32'hdeadbeef, 32'h000000ff, 1'b1);
    send_request(OP_WRITE, 8'hff, 32'ha5a55a5a, 32'hffffffff, 1'b0);
    send_request(OP_WRITE, 8'hfc, 32'h0000ffff, 32'h00000001, 1'b1);
    repeat (3) send_tick();

    // longest delay: fill the ring until writes overflow
    set_release_delay(16'hffff);
    repeat (66) send_request(OP_WRITE, 8'($urandom_range(255)), $urandom, 32'hffffffff,
                             1'($urandom_range(1)));
    repeat (2) send_tick();

    // zero delay drains the whole ring on one tick
    set_release_delay(16'h0000);
    repeat (2) send_tick();

    for (int p = 0; p < 7; p++) begin
      set_release_delay(p == 4 ? 16'($urandom_range(1, 40)) : phase_delays[p]);
      calm <= (p == 2);
      repeat (50) begin
        if ($urandom_range(99) < 55) send_random_write();
        else send_tick();
      end
      calm <= 1'b0;
    end

    // release times wrap past zero: entries stay queued while ticks run
    set_release_delay(16'h0000);
    send_tick();
    set_release_delay(16'hffff);
    repeat (4) send_request(OP_WRITE, 8'($urandom_range(255)), $urandom, 32'hffffffff,
                            1'($urandom_range(1)));
    calm <= 1'b1;
    repeat (10) send_tick();
    calm <= 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (writes_owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("delayed_register_write_queue_core_tb: done, clean");
    end else begin
      $display("delayed_register_write_queue_core_tb: done, errors");
    end
    $finish;
  end

endmodule
